[rtl/dcwm_pkg.sv]
// ----------------------------------------------------------------------------
// dcwm_pkg
// Shared types, constants and helpers for the dark channel window minimum.
// ----------------------------------------------------------------------------
`default_nettype none

package dcwm_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned IMG_H_W = 13;
  localparam int unsigned RAD_W   = 3;
  localparam int unsigned CFG_W   = 13;
  // padded column and row counters, wide enough for the largest register values
  localparam int unsigned COL_W   = 12;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned SPAN_W  = 4;
  localparam int unsigned MAX_SPAN = 14;

  localparam logic [PIX_W-1:0] PAD_VALUE = 8'hFF;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_RADIUS       = 2'd2
  } dcwm_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } dcwm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] dark_value;
    logic             center_inside;
    logic             frame_done;
  } dcwm_out_t;

  typedef struct packed {
    logic rd_en;
    logic step_en;
    logic first;
  } dcwm_cell_ctl_t;

  function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[rtl/dcwm_cell.sv]
// ----------------------------------------------------------------------------
// dcwm_cell
// One window cell: a line slot of per-pixel minima and one running
// horizontal minimum tap handed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dcwm_cell #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dcwm_pkg::dcwm_cell_ctl_t     ctl_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                addr_i,
  input  logic [dcwm_pkg::PIX_W-1:0]   wdata_i,
  output logic [dcwm_pkg::PIX_W-1:0]   rdata_o,
  input  logic [dcwm_pkg::PIX_W-1:0]   v_i,
  input  logic [dcwm_pkg::PIX_W-1:0]   m_prev_i,
  output logic [dcwm_pkg::PIX_W-1:0]   m_o
);
  import dcwm_pkg::*;

  logic [PIX_W-1:0] mem_q [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic [PIX_W-1:0] m_q, m_d;

  // read returns the value held before a write at the same address
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // first column of a row drops everything left of it
  assign m_d = min8(v_i, ctl_i.first ? PAD_VALUE : m_prev_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= PAD_VALUE;
    end else if (ctl_i.step_en) begin
      m_q <= m_d;
    end
  end

  assign rdata_o = rdata_q;
  assign m_o     = m_q;

endmodule

`default_nettype wire

[rtl/dcwm_rowmod.sv]
// ----------------------------------------------------------------------------
// dcwm_rowmod
// Tracks row mod span for line slot selection; recomputed bit-serially
// after a radius change.
// ----------------------------------------------------------------------------
`default_nettype none

module dcwm_rowmod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        inc_i,
  input  logic                        clr_i,
  input  logic [dcwm_pkg::ROW_W-1:0]  row_i,
  input  logic [dcwm_pkg::SPAN_W-1:0] span_i,
  output logic                        busy_o,
  output logic [dcwm_pkg::SPAN_W-1:0] rem_o
);
  import dcwm_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROW_W + 1);
  localparam int unsigned IDX_W = $clog2(ROW_W);

  logic [SPAN_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [IDX_W-1:0]  bit_idx;
  logic [SPAN_W:0]   shifted;
  logic [SPAN_W-1:0] rem_step;
  logic [SPAN_W-1:0] rem_inc;

  assign bit_idx = (cnt_q == '0) ? '0 : IDX_W'(cnt_q - CNT_W'(1));

  // restoring remainder, one row bit per cycle, msb first
  always_comb begin
    shifted = {rem_q, row_i[bit_idx]};
    if (shifted >= {1'b0, span_i}) begin
      rem_step = SPAN_W'(shifted - {1'b0, span_i});
    end else begin
      rem_step = shifted[SPAN_W-1:0];
    end
    rem_inc = rem_q + SPAN_W'(1);
    if (rem_inc == span_i) begin
      rem_inc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      cnt_q  <= CNT_W'(ROW_W);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      rem_q <= rem_step;
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end else if (clr_i) begin
      rem_q <= '0;
    end else if (inc_i) begin
      rem_q <= rem_inc;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[rtl/dark_channel_window_min_top.sv]
// ----------------------------------------------------------------------------
// dark_channel_window_min_top
// Streaming dark channel: colour minimum, then a square window minimum
// built from a chain of cells, each holding one line slot and one tap.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (blue, green, red)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (dark, inside, done)
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while no stall holds the input; an item is
// registered with the line memory read, then after the vertical compare tree,
// then in the output register. after reset the line memories are swept to 255,
// one column address per cycle, with input stalled. a radius write stalls input
// while row mod span is recomputed. an output stall only holds the input once
// every pipeline stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dark_channel_window_min_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dcwm_pkg::dcwm_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dcwm_pkg::dcwm_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [dcwm_pkg::CFG_W-1:0] cfg_data_i
);
  import dcwm_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned NCELL = (2 * MAX_RADIUS < MAX_SPAN) ? 2 * MAX_RADIUS : MAX_SPAN;
  localparam int unsigned LEAVES = 16;

  // configuration
  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic [RAD_W-1:0]   radius_q;
  logic               radius_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMG_W_W'(640);
      height_q <= IMG_H_W'(480);
      radius_q <= RAD_W'(7);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[IMG_H_W-1:0];
        REG_RADIUS:       radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign radius_start = cfg_we_i && (cfg_index_i == REG_RADIUS);

  // effective geometry
  logic [COL_W-1:0]  eff_w, pad_w;
  logic [ROW_W-1:0]  eff_h, pad_h;
  logic [RAD_W-1:0]  eff_r;
  logic [SPAN_W-1:0] span;

  always_comb begin
    if (width_q == '0) begin
      eff_w = COL_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(width_q);
    end
    eff_h = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
    if (radius_q == '0) begin
      eff_r = RAD_W'(1);
    end else if (int'(radius_q) > MAX_RADIUS) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = radius_q;
    end
    span  = {eff_r, 1'b0};
    pad_w = eff_w + COL_W'(eff_r);
    pad_h = eff_h + ROW_W'(eff_r);
  end

  // reset sweep of the line memories
  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // pipeline handshake
  logic b_v_q, c_v_q, out_v_q;
  logic en_b, en_c, en_out;
  logic mod_busy;
  logic acc;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en_c       = !c_v_q || en_out;
  assign en_b       = !b_v_q || en_c;
  assign in_stall_o = !en_b || mod_busy || clr_active_q || cfg_we_i;
  assign acc        = in_valid_i && !in_stall_o;

  // front: counters and per-item decisions
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              col_in, pix_in, ctr_in, last_col, last_row;
  logic [PIX_W-1:0]  pix;
  logic [SPAN_W-1:0] lim;
  logic [SPAN_W-1:0] row_mod;
  logic [NCELL-1:0]  mask;

  always_comb begin
    col_in   = col_q < eff_w;
    pix_in   = col_in && (row_q < eff_h);
    pix      = pix_in ? min8(min8(in_data_i.blue, in_data_i.green), in_data_i.red)
                      : PAD_VALUE;
    ctr_in   = (row_q >= ROW_W'(eff_r)) && (col_q >= COL_W'(eff_r));
    last_col = ({1'b0, col_q} + (COL_W+1)'(1)) >= {1'b0, pad_w};
    last_row = ({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, pad_h};
    // rows above the frame start are not read
    lim      = (row_q < ROW_W'(span)) ? row_q[SPAN_W-1:0] : span;
    for (int s = 0; s < NCELL; s++) begin
      mask[s] = SPAN_W'(s) < lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  dcwm_rowmod u_rowmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(radius_start),
    .inc_i  (acc && last_col && !last_row),
    .clr_i  (acc && last_col && last_row),
    .row_i  (row_q),
    .span_i (span),
    .busy_o (mod_busy),
    .rem_o  (row_mod)
  );

  // stage b registers
  logic [PIX_W-1:0] b_pix_q;
  logic [NCELL-1:0] b_mask_q;
  logic             b_colin_q, b_col0_q, b_inside_q, b_done_q;
  // stage c registers
  logic [PIX_W-1:0] c_vmin_q;
  logic             c_col0_q, c_inside_q, c_done_q;
  dcwm_out_t        out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_b) begin
        b_v_q <= acc;
      end
      if (en_c) begin
        c_v_q <= b_v_q;
      end
      if (en_out) begin
        out_v_q <= c_v_q;
      end
    end
  end

  // chain of cells
  dcwm_cell_ctl_t   cell_ctl;
  logic [AW-1:0]    cell_addr;
  logic [PIX_W-1:0] cell_wdata;
  logic [PIX_W-1:0] rd   [NCELL];
  logic [PIX_W-1:0] tap  [NCELL];

  assign cell_ctl.rd_en   = acc;
  assign cell_ctl.step_en = c_v_q && en_out;
  assign cell_ctl.first   = c_col0_q;
  assign cell_addr        = clr_active_q ? clr_addr_q : col_q[AW-1:0];
  assign cell_wdata       = clr_active_q ? PAD_VALUE : pix;

  for (genvar s = 0; s < NCELL; s++) begin : g_cell
    logic wr;
    logic [PIX_W-1:0] m_prev;
    assign wr = clr_active_q || (acc && col_in && (row_mod == SPAN_W'(s)));
    if (s == 0) begin : g_head
      assign m_prev = PAD_VALUE;
    end else begin : g_link
      assign m_prev = tap[s-1];
    end
    dcwm_cell #(.DEPTH(MAX_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .wr_en_i (wr),
      .addr_i  (cell_addr),
      .wdata_i (cell_wdata),
      .rdata_o (rd[s]),
      .v_i     (c_vmin_q),
      .m_prev_i(m_prev),
      .m_o     (tap[s])
    );
  end

  // stage b: vertical minimum over the current pixel and the stored rows
  logic [PIX_W-1:0] leaf [LEAVES];
  logic [PIX_W-1:0] t1 [8];
  logic [PIX_W-1:0] t2 [4];
  logic [PIX_W-1:0] t3 [2];
  logic [PIX_W-1:0] vmin;

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < NCELL) begin : g_row
      assign leaf[i] = b_mask_q[i] ? rd[i] : PAD_VALUE;
    end else if (i == NCELL) begin : g_pix
      assign leaf[i] = b_pix_q;
    end else begin : g_pad
      assign leaf[i] = PAD_VALUE;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      t1[i] = min8(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      t2[i] = min8(t1[2*i], t1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      t3[i] = min8(t2[2*i], t2[2*i+1]);
    end
    vmin = b_colin_q ? min8(t3[0], t3[1]) : PAD_VALUE;
  end

  // stage c: horizontal minimum from the tap that covers the window
  logic [PIX_W-1:0] win_tap;
  logic [PIX_W-1:0] dark;

  always_comb begin
    win_tap = PAD_VALUE;
    for (int k = 0; k < NCELL; k++) begin
      if (span == SPAN_W'(k + 1)) begin
        win_tap = tap[k];
      end
    end
    dark = c_col0_q ? c_vmin_q : min8(c_vmin_q, win_tap);
  end

  always_ff @(posedge clk_i) begin
    if (en_b && acc) begin
      b_pix_q    <= pix;
      b_mask_q   <= mask;
      b_colin_q  <= col_in;
      b_col0_q   <= (col_q == '0);
      b_inside_q <= ctr_in;
      b_done_q   <= last_col && last_row;
    end
    if (en_c && b_v_q) begin
      c_vmin_q   <= vmin;
      c_col0_q   <= b_col0_q;
      c_inside_q <= b_inside_q;
      c_done_q   <= b_done_q;
    end
    if (en_out && c_v_q) begin
      out_q.dark_value    <= c_inside_q ? dark : '0;
      out_q.center_inside <= c_inside_q;
      out_q.frame_done    <= c_done_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[tb/sv/tb_dark_channel_window_min_top.sv]
// ----------------------------------------------------------------------------
// tb_dark_channel_window_min_top
// Self-checking bench for the streaming dark channel window minimum. A short
// table of directed items and register writes comes first, then random frames
// over many image sizes and radii. Each result is checked against an in-bench
// model of the line store and window, or a typed directed item's own want,
// with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dark_channel_window_min_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcwm_pkg::*;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_R         = 7;
  localparam int unsigned WIN_TAPS      = 2 * MAX_R;
  localparam int unsigned RANDOM_ITEMS  = 550;
  localparam int unsigned QUIET_FROM    = 450;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    dcwm_reg_e        reg_idx;
    logic [CFG_W-1:0] cfg_val;
    dcwm_in_t         px;
    logic             typed;
    dcwm_out_t        want;
  } stim_row_t;

  // centre outside the image, not the end of the frame
  localparam dcwm_out_t NO_CENTER = '0;
  localparam int unsigned DIR_ROWS = 29;

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // reset settings: 640 x 480, radius 7
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, NO_CENTER},
    // zero registers are taken as one
    '{ROW_REG,   REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 13'd0,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_RADIUS,       13'd0,    24'h000000, 1'b0, NO_CENTER},
    // column already past the padded width, wraps to the next row
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h123456, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h0A0B0C, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h5A5A5A, 1'b0, NO_CENTER},
    // one full 2 x 2 padded frame
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h804090, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, NO_CENTER},
    // oversize width; width and radius with bits beyond the register width set
    '{ROW_REG,   REG_IMAGE_WIDTH,  13'h1FFF, 24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 13'd1,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_RADIUS,       13'h1FFF, 24'h000000, 1'b0, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h00FFFF, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFF00FF, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFF00, 1'b1, NO_CENTER},
    // largest legal width and radius
    '{ROW_REG,   REG_IMAGE_WIDTH,  13'd1024, 24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 13'h1000, 24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_RADIUS,       13'd7,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h7F7F7F, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h808080, 1'b1, NO_CENTER},
    // shrink in mid-frame
    '{ROW_REG,   REG_IMAGE_WIDTH,  13'd3,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_IMAGE_HEIGHT, 13'd2,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_REG,   REG_RADIUS,       13'd2,    24'h000000, 1'b0, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h55AA33, 1'b1, NO_CENTER},
    '{ROW_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hAA55CC, 1'b1, NO_CENTER}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  dcwm_in_t         in_data;
  logic             out_valid;
  logic             out_stall;
  dcwm_out_t        out_data;
  logic             cfg_we;
  dcwm_reg_e        cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  // hand-typed expectation travelling with the item
  logic             typed_flag;
  dcwm_out_t        typed_want;

  bit               idle_on;
  bit               hold_req;
  int               mismatch_cnt;
  dcwm_out_t        pending_dark_q [$];

  // model state
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;
  logic [RAD_W-1:0]   rad_q;
  logic [PIX_W-1:0]   col_taps [WIN_TAPS];
  logic [PIX_W-1:0]   line_mem [2*MAX_R*MAX_W];
  int unsigned        col_pos;
  int unsigned        row_pos;

  dark_channel_window_min_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void eff_dims(output int unsigned w, output int unsigned h,
                                   output int unsigned r);
    w = (img_w_q == 0) ? 1 : (img_w_q > MAX_W) ? MAX_W : img_w_q;
    h = (img_h_q == 0) ? 1 : img_h_q;
    r = (rad_q == 0) ? 1 : (rad_q > MAX_R) ? MAX_R : rad_q;
  endfunction

  function automatic dcwm_out_t dark_channel_step(input dcwm_in_t px);
    int unsigned w, h, r, span, col, row, k, slot;
    logic [PIX_W-1:0] p, v, dark;
    logic ctr_in, last_col, last_row;
    dcwm_out_t res;
    eff_dims(w, h, r);
    span = 2 * r;
    col = col_pos;
    row = row_pos;
    p = PAD_VALUE;
    if (row < h && col < w) begin
      p = (px.blue < px.green) ? px.blue : px.green;
      if (px.red < p) p = px.red;
    end
    // vertical minimum over this row and the span rows above it in the frame
    v = p;
    if (col < w) begin
      for (k = 1; k <= span; k++) begin
        if (row >= k) begin
          slot = (row - k) % span;
          if (line_mem[slot*MAX_W + col] < v) v = line_mem[slot*MAX_W + col];
        end
      end
      line_mem[(row % span)*MAX_W + col] = p;
    end else begin
      v = PAD_VALUE;
    end
    // horizontal minimum over the span previous columns of this row
    if (col == 0) begin
      for (k = 0; k < WIN_TAPS; k++) col_taps[k] = PAD_VALUE;
    end
    dark = v;
    for (k = 0; k < span; k++) begin
      if (col_taps[k] < dark) dark = col_taps[k];
    end
    for (k = WIN_TAPS - 1; k > 0; k--) col_taps[k] = col_taps[k-1];
    col_taps[0] = v;
    ctr_in   = (row >= r) && (col >= r);
    last_col = (col + 1 >= w + r);
    last_row = (row + 1 >= h + r);
    res.dark_value    = ctr_in ? dark : '0;
    res.center_inside = ctr_in;
    res.frame_done    = last_col && last_row;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    dcwm_out_t want;
    dcwm_out_t got;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_IMAGE_WIDTH:  img_w_q = cfg_data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: img_h_q = cfg_data[IMG_H_W-1:0];
          REG_RADIUS:       rad_q   = cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = dark_channel_step(in_data);
        if (typed_flag) want = typed_want;
        pending_dark_q.insert(pending_dark_q.size(), want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_dark_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected item dark %0d inside %0b done %0b", $realtime,
                     got.dark_value, got.center_inside, got.frame_done);
          mismatch_cnt++;
        end else begin
          want = pending_dark_q.pop_front();
          if (got.dark_value !== want.dark_value ||
              got.center_inside !== want.center_inside ||
              got.frame_done !== want.frame_done) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch dark %0d/%0d inside %0b/%0b done %0b/%0b (exp/got)",
                       $realtime, want.dark_value, got.dark_value, want.center_inside,
                       got.center_inside, want.frame_done, got.frame_done);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // output side: random stall bursts and one long hold-off
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_pixel(input dcwm_in_t px, input logic typed, input dcwm_out_t want);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid   <= 1'b1;
    in_data    <= px;
    typed_flag <= typed;
    typed_want <= want;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain_items();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_dark_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input dcwm_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int i, sent, n, area, floor_lvl, phase;
    int unsigned w, h, r;
    dcwm_in_t px;
    logic [CFG_W-1:0] val;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_IMAGE_WIDTH;
    cfg_data   = '0;
    typed_flag = 1'b0;
    typed_want = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    mismatch_cnt = 0;
    img_w_q = 11'd640;
    img_h_q = 13'd480;
    rad_q   = 3'd7;
    foreach (col_taps[k]) col_taps[k] = PAD_VALUE;
    foreach (line_mem[k]) line_mem[k] = PAD_VALUE;
    col_pos = 0;
    row_pos = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        drain_items();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].cfg_val);
      end else begin
        push_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_items();
      // mostly small frames, now and then an extreme or out-of-range value
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       val = 13'd0;
            1:       val = 13'd1024;
            2:       val = 13'($urandom_range(1025, 2047));
            default: val = 13'($urandom_range(1, 1024));
          endcase
        end else begin
          val = 13'($urandom_range(1, 12));
        end
        val[CFG_W-1:IMG_W_W] = 2'($urandom_range(0, 3));
        write_reg(REG_IMAGE_WIDTH, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       val = 13'd0;
            1:       val = 13'h1000;
            default: val = 13'($urandom_range(1, 8191));
          endcase
        end else begin
          val = 13'($urandom_range(1, 8));
        end
        write_reg(REG_IMAGE_HEIGHT, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        val = 13'($urandom_range(0, 8191));
        if ($urandom_range(0, 7) != 0) val[RAD_W-1:0] = 3'($urandom_range(1, 7));
        write_reg(REG_RADIUS, val);
      end

      eff_dims(w, h, r);
      area = (w + r) * (h + r);
      n = (area <= 100) ? 2 * area + $urandom_range(0, area) : $urandom_range(20, 60);
      if (n > 200) n = 200;
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      floor_lvl = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(64, 250);
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) hold_req = 1'b1;

      repeat (n) begin
        if (sent >= QUIET_FROM) idle_on = 1'b0;
        px.blue  = 8'($urandom_range(floor_lvl, 255));
        px.green = 8'($urandom_range(floor_lvl, 255));
        px.red   = 8'($urandom_range(floor_lvl, 255));
        // occasional dark spot on one channel
        if ($urandom_range(0, 15) == 0) begin
          case ($urandom_range(0, 2))
            0:       px.blue  = 8'($urandom_range(0, 255));
            1:       px.green = 8'($urandom_range(0, 255));
            default: px.red   = 8'($urandom_range(0, 255));
          endcase
        end
        push_pixel(px, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain_items();
    if (mismatch_cnt == 0 && pending_dark_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

[dark_channel_window_min_top.f]
rtl/dcwm_pkg.sv
rtl/dcwm_cell.sv
rtl/dcwm_rowmod.sv
rtl/dark_channel_window_min_top.sv
tb/sv/tb_dark_channel_window_min_top.sv
